// ----- hdl/assert_macros.svh -----
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_PROP(label, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- hdl/e2r_pkg.sv -----
package e2r_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int OUT_FRAC_BITS   = 14;

	localparam int ANG_W = 18;
	localparam int OUT_W = 16;
	localparam int RED_W = 17;
	localparam int E_W   = 15;
	localparam int T_W   = 14;
	localparam int PA_W  = 30;
	localparam int Y_W   = 28;
	localparam int Z_W   = 18;
	localparam int RC_W  = 19;
	localparam int X_W   = 30;
	localparam int Q_W   = 32;

	localparam int SC_LAT = 19;

	localparam int FULL_A    = 360 << ANGLE_FRAC_BITS;
	localparam int QUARTER_A = 90 << ANGLE_FRAC_BITS;
	localparam int EIGHTH_A  = 45 << ANGLE_FRAC_BITS;
	localparam int HALF_A    = 180 << ANGLE_FRAC_BITS;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] PI_HI  = PI_Q30 / 64'(HALF_A);
	localparam logic [63:0] PI_LO  = PI_Q30 - PI_HI * 64'(HALF_A);

	localparam int Y_SH     = ANGLE_FRAC_BITS + 2;
	localparam int RECIP_SH = 24;
	localparam logic [RC_W-1:0] RECIP_45 = RC_W'(((64'd1 << RECIP_SH) + 64'd44) / 64'd45);

	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [61:0] HALF_Q30 = 62'd1 << 29;

	localparam int unsigned COS_J  [5] = '{1, 3, 1, 2, 1};
	localparam int unsigned COS_S  [5] = '{36, 33, 34, 32, 30};
	localparam int unsigned COS_HK [5] = '{45, 28, 15, 6, 1};
	localparam logic [30:0] COS_M  [5] = '{
		31'(((64'd1 << 36) + 64'd44) / 64'd45),
		31'(((64'd1 << 33) + 64'd6) / 64'd7),
		31'(((64'd1 << 34) + 64'd14) / 64'd15),
		31'(((64'd1 << 32) + 64'd2) / 64'd3),
		31'(64'd1 << 30)
	};

	localparam int unsigned SIN_J  [4] = '{3, 1, 2, 1};
	localparam int unsigned SIN_S  [4] = '{34, 35, 33, 32};
	localparam int unsigned SIN_HK [4] = '{36, 21, 10, 3};
	localparam logic [30:0] SIN_M  [4] = '{
		31'(((64'd1 << 34) + 64'd8) / 64'd9),
		31'(((64'd1 << 35) + 64'd20) / 64'd21),
		31'(((64'd1 << 33) + 64'd4) / 64'd5),
		31'(((64'd1 << 32) + 64'd2) / 64'd3)
	};

	localparam int OUT_SH = 30 - OUT_FRAC_BITS;
	localparam logic [32:0] OUT_RND = 33'd1 << (OUT_SH - 1);
	localparam logic [32:0] OUT_LIM = 33'd1 << OUT_FRAC_BITS;
	localparam logic signed [OUT_W-1:0] OUT_ONE = OUT_W'(1 << OUT_FRAC_BITS);

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [X_W-1:0] x2;
		logic [1:0]     quad;
		logic           swap;
	} e2r_side_t;

	typedef struct packed {
		logic        neg;
		logic [61:0] mag;
	} e2r_prod_t;

	function automatic logic [30:0] rnd30(input logic [61:0] p);
		logic [61:0] s;
		s = (p + HALF_Q30) >> 30;
		return s[30:0];
	endfunction

	function automatic logic [30:0] mag31(input logic signed [Q_W-1:0] v);
		logic [Q_W-1:0] m;
		m = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
		return m[30:0];
	endfunction

	function automatic e2r_prod_t smul(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		e2r_prod_t r;
		r.neg = a[Q_W-1] ^ b[Q_W-1];
		r.mag = 62'(mag31(a)) * 62'(mag31(b));
		return r;
	endfunction

	function automatic logic signed [Q_W-1:0] sround(input e2r_prod_t p);
		logic signed [Q_W-1:0] v;
		v = $signed({1'b0, rnd30(p.mag)});
		return p.neg ? -v : v;
	endfunction

	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [32:0] v);
		logic [32:0] m;
		logic [32:0] r;
		m = v[32] ? 33'(-v) : 33'(v);
		r = (m + OUT_RND) >> OUT_SH;
		if (r > OUT_LIM)
			r = OUT_LIM;
		return v[32] ? -OUT_W'(r) : OUT_W'(r);
	endfunction

endpackage

// ----- hdl/euler_to_rotation_matrix_unit.sv -----
// Each accepted input word passes through the sine/cosine pipeline, then the matrix pipeline, to its result word.
// Throughput: one word per cycle; the 19-stage sine/cosine pipeline and the
// 6-stage matrix pipeline advance together and freeze while out_stall holds a result.
// Reset: arst_n clears the valid bits of every stage at once; data registers keep
// their contents.
`include "assert_macros.svh"

module euler_to_rotation_matrix_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [e2r_pkg::ANG_W-1:0]     pitch_deg,
	input  logic signed [e2r_pkg::ANG_W-1:0]     yaw_deg,
	input  logic signed [e2r_pkg::ANG_W-1:0]     roll_deg,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [e2r_pkg::OUT_W-1:0]     fwd_x,
	output logic signed [e2r_pkg::OUT_W-1:0]     fwd_y,
	output logic signed [e2r_pkg::OUT_W-1:0]     fwd_z,
	output logic signed [e2r_pkg::OUT_W-1:0]     right_x,
	output logic signed [e2r_pkg::OUT_W-1:0]     right_y,
	output logic signed [e2r_pkg::OUT_W-1:0]     right_z,
	output logic signed [e2r_pkg::OUT_W-1:0]     up_x,
	output logic signed [e2r_pkg::OUT_W-1:0]     up_y,
	output logic signed [e2r_pkg::OUT_W-1:0]     up_z
);
	import e2r_pkg::*;

	localparam int LAT = SC_LAT + 6;

	localparam int P_CPCY = 0;
	localparam int P_CPSY = 1;
	localparam int P_SRSP = 2;
	localparam int P_CRSP = 3;
	localparam int P_CRSY = 4;
	localparam int P_CRCY = 5;
	localparam int P_CPSR = 6;
	localparam int P_SRSY = 7;
	localparam int P_SRCY = 8;
	localparam int P_CPCR = 9;

	localparam int Q_SRSPCY = 0;
	localparam int Q_SRSPSY = 1;
	localparam int Q_CRSPCY = 2;
	localparam int Q_CRSPSY = 3;

	logic                  en;
	logic [LAT-1:0]        vld_q;

	logic signed [Q_W-1:0] sp;
	logic signed [Q_W-1:0] cp;
	logic signed [Q_W-1:0] sy;
	logic signed [Q_W-1:0] cy;
	logic signed [Q_W-1:0] sr;
	logic signed [Q_W-1:0] cr;

	e2r_prod_t             prod_s20 [10];
	logic signed [Q_W-1:0] sp_s20;
	logic signed [Q_W-1:0] sy_s20;
	logic signed [Q_W-1:0] cy_s20;
	logic signed [Q_W-1:0] rnd_s21 [10];
	logic signed [Q_W-1:0] sp_s21;
	logic signed [Q_W-1:0] sy_s21;
	logic signed [Q_W-1:0] cy_s21;
	e2r_prod_t             prod_s22 [4];
	logic signed [Q_W-1:0] rnd_s22 [10];
	logic signed [Q_W-1:0] sp_s22;
	logic signed [Q_W-1:0] rnd_s23 [10];
	logic signed [Q_W-1:0] rnd2_s23 [4];
	logic signed [Q_W-1:0] sp_s23;
	logic signed [32:0]    ent_s24 [9];
	logic signed [OUT_W-1:0] out_s25 [9];

	assign en       = ~(vld_q[LAT-1] & out_stall);
	assign in_stall = ~en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	e2r_sincos u_pitch (.clk(clk), .en(en), .angle(pitch_deg), .sin_q30(sp), .cos_q30(cp));
	e2r_sincos u_yaw   (.clk(clk), .en(en), .angle(yaw_deg),   .sin_q30(sy), .cos_q30(cy));
	e2r_sincos u_roll  (.clk(clk), .en(en), .angle(roll_deg),  .sin_q30(sr), .cos_q30(cr));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s20[P_CPCY] <= smul(cp, cy);
			prod_s20[P_CPSY] <= smul(cp, sy);
			prod_s20[P_SRSP] <= smul(sr, sp);
			prod_s20[P_CRSP] <= smul(cr, sp);
			prod_s20[P_CRSY] <= smul(cr, sy);
			prod_s20[P_CRCY] <= smul(cr, cy);
			prod_s20[P_CPSR] <= smul(cp, sr);
			prod_s20[P_SRSY] <= smul(sr, sy);
			prod_s20[P_SRCY] <= smul(sr, cy);
			prod_s20[P_CPCR] <= smul(cp, cr);
			sp_s20 <= sp;
			sy_s20 <= sy;
			cy_s20 <= cy;

			for (int k = 0; k < 10; k++)
				rnd_s21[k] <= sround(prod_s20[k]);
			sp_s21 <= sp_s20;
			sy_s21 <= sy_s20;
			cy_s21 <= cy_s20;

			prod_s22[Q_SRSPCY] <= smul(rnd_s21[P_SRSP], cy_s21);
			prod_s22[Q_SRSPSY] <= smul(rnd_s21[P_SRSP], sy_s21);
			prod_s22[Q_CRSPCY] <= smul(rnd_s21[P_CRSP], cy_s21);
			prod_s22[Q_CRSPSY] <= smul(rnd_s21[P_CRSP], sy_s21);
			rnd_s22 <= rnd_s21;
			sp_s22  <= sp_s21;

			for (int k = 0; k < 4; k++)
				rnd2_s23[k] <= sround(prod_s22[k]);
			rnd_s23 <= rnd_s22;
			sp_s23  <= sp_s22;

			ent_s24[0] <= 33'(rnd_s23[P_CPCY]);
			ent_s24[1] <= 33'(rnd_s23[P_CPSY]);
			ent_s24[2] <= 33'(sp_s23);
			ent_s24[3] <= 33'(rnd2_s23[Q_SRSPCY]) - 33'(rnd_s23[P_CRSY]);
			ent_s24[4] <= 33'(rnd2_s23[Q_SRSPSY]) + 33'(rnd_s23[P_CRCY]);
			ent_s24[5] <= -33'(rnd_s23[P_CPSR]);
			ent_s24[6] <= -(33'(rnd2_s23[Q_CRSPCY]) + 33'(rnd_s23[P_SRSY]));
			ent_s24[7] <= -(33'(rnd2_s23[Q_CRSPSY]) - 33'(rnd_s23[P_SRCY]));
			ent_s24[8] <= 33'(rnd_s23[P_CPCR]);

			for (int k = 0; k < 9; k++)
				out_s25[k] <= to_out(ent_s24[k]);
		end
	end

	assign fwd_x   = out_s25[0];
	assign fwd_y   = out_s25[1];
	assign fwd_z   = out_s25[2];
	assign right_x = out_s25[3];
	assign right_y = out_s25[4];
	assign right_z = out_s25[5];
	assign up_x    = out_s25[6];
	assign up_y    = out_s25[7];
	assign up_z    = out_s25[8];

	`ASSERT_PROP(a_stall_freeze, clk, arst_n, (out_valid && out_stall) |=> $stable(vld_q))
	`ASSERT_NEVER(a_fwd_right_sat, clk, arst_n, out_valid && (fwd_x > OUT_ONE || fwd_x < -OUT_ONE || fwd_y > OUT_ONE || fwd_y < -OUT_ONE || fwd_z > OUT_ONE || fwd_z < -OUT_ONE || right_x > OUT_ONE || right_x < -OUT_ONE || right_y > OUT_ONE || right_y < -OUT_ONE || right_z > OUT_ONE || right_z < -OUT_ONE))
	`ASSERT_NEVER(a_up_sat, clk, arst_n, out_valid && (up_x > OUT_ONE || up_x < -OUT_ONE || up_y > OUT_ONE || up_y < -OUT_ONE || up_z > OUT_ONE || up_z < -OUT_ONE))

endmodule

// ----- hdl/e2r_sincos.sv -----
module e2r_sincos (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [e2r_pkg::ANG_W-1:0]    angle,
	output logic signed [e2r_pkg::Q_W-1:0]      sin_q30,
	output logic signed [e2r_pkg::Q_W-1:0]      cos_q30
);
	import e2r_pkg::*;

	localparam logic signed [19:0] FULL_S  = 20'(FULL_A);
	localparam logic signed [19:0] FULL2_S = 20'(2 * FULL_A);

	logic signed [19:0] a_ext;
	logic signed [19:0] red;
	logic [RED_W-1:0]   red_s1;
	logic [1:0]         quad_c;
	logic [RED_W-1:0]   e_c;
	logic [1:0]         quad_s2;
	logic [E_W-1:0]     e_s2;
	logic [1:0]         quad_s3;
	logic               swap_s3;
	logic [T_W-1:0]     t_s3;
	logic [1:0]         quad_s4;
	logic               swap_s4;
	logic [PA_W-1:0]    pa_s4;
	logic [Y_W-1:0]     y_s4;
	logic [1:0]         quad_s5;
	logic               swap_s5;
	logic [PA_W-1:0]    pa_s5;
	logic [Z_W+RC_W-1:0] pz_s5;
	logic [1:0]         quad_s6;
	logic               swap_s6;
	logic [X_W-1:0]     x_s6;
	logic [1:0]         quad_s7;
	logic               swap_s7;
	logic [X_W-1:0]     x_s7;
	logic [2*X_W-1:0]   xx_s7;
	e2r_side_t          side_s8;

	logic [60:0]        cmh_a [5];
	logic [60:0]        smh_a [5];
	e2r_side_t          side_a [5];
	logic [60:0]        cpd_b [5];
	logic [60:0]        spd_b [4];
	e2r_side_t          side_b [5];
	logic [30:0]        s_b4;

	logic [30:0]        c_fin;
	logic [30:0]        ss;
	logic [30:0]        cc;
	logic signed [Q_W-1:0] ss_v;
	logic signed [Q_W-1:0] cc_v;
	logic signed [Q_W-1:0] sin_s19;
	logic signed [Q_W-1:0] cos_s19;

	assign a_ext = {{2{angle[ANG_W-1]}}, angle};

	always_comb begin
		if (a_ext < -FULL_S)
			red = a_ext + FULL2_S;
		else if (a_ext < 0)
			red = a_ext + FULL_S;
		else if (a_ext >= FULL_S)
			red = a_ext - FULL_S;
		else
			red = a_ext;
	end

	always_comb begin
		if (red_s1 >= RED_W'(3 * QUARTER_A)) begin
			quad_c = 2'd3;
			e_c    = red_s1 - RED_W'(3 * QUARTER_A);
		end else if (red_s1 >= RED_W'(2 * QUARTER_A)) begin
			quad_c = 2'd2;
			e_c    = red_s1 - RED_W'(2 * QUARTER_A);
		end else if (red_s1 >= RED_W'(QUARTER_A)) begin
			quad_c = 2'd1;
			e_c    = red_s1 - RED_W'(QUARTER_A);
		end else begin
			quad_c = 2'd0;
			e_c    = red_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1  <= red[RED_W-1:0];

			quad_s2 <= quad_c;
			e_s2    <= e_c[E_W-1:0];

			quad_s3 <= quad_s2;
			swap_s3 <= e_s2 > E_W'(EIGHTH_A);
			t_s3    <= (e_s2 > E_W'(EIGHTH_A)) ? T_W'(E_W'(QUARTER_A) - e_s2) : T_W'(e_s2);

			quad_s4 <= quad_s3;
			swap_s4 <= swap_s3;
			pa_s4   <= PA_W'(PA_W'(t_s3) * PA_W'(PI_HI));
			y_s4    <= Y_W'(Y_W'(t_s3) * Y_W'(PI_LO) + Y_W'(QUARTER_A));

			quad_s5 <= quad_s4;
			swap_s5 <= swap_s4;
			pa_s5   <= pa_s4;
			pz_s5   <= (Z_W+RC_W)'(Z_W'(y_s4 >> Y_SH)) * (Z_W+RC_W)'(RECIP_45);

			quad_s6 <= quad_s5;
			swap_s6 <= swap_s5;
			x_s6    <= pa_s5 + X_W'(pz_s5 >> RECIP_SH);

			quad_s7 <= quad_s6;
			swap_s7 <= swap_s6;
			x_s7    <= x_s6;
			xx_s7   <= (2*X_W)'(x_s6) * (2*X_W)'(x_s6);

			side_s8.x    <= x_s7;
			side_s8.x2   <= X_W'(rnd30({2'b00, xx_s7}));
			side_s8.quad <= quad_s7;
			side_s8.swap <= swap_s7;
		end
	end

	for (genvar i = 0; i < 5; i++) begin : g_it
		logic [30:0] ch;
		logic [30:0] sh;
		e2r_side_t   side_in;
		logic [30:0] cp_r;
		logic [31:0] cv;
		logic [29:0] cw;

		if (i == 0) begin : g_first
			assign ch      = ONE_Q30;
			assign sh      = ONE_Q30;
			assign side_in = side_s8;
		end else begin : g_next
			assign ch      = ONE_Q30 - 31'(cpd_b[i-1] >> COS_S[i-1]);
			assign sh      = ONE_Q30 - 31'(spd_b[i-1] >> SIN_S[i-1]);
			assign side_in = side_b[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cmh_a[i]  <= 61'(side_in.x2) * 61'(ch);
				side_a[i] <= side_in;
			end
		end

		if (i == 4) begin : g_sfin_a
			always_ff @(posedge clk) begin
				if (en)
					smh_a[i] <= 61'(side_in.x) * 61'(sh);
			end
		end else begin : g_sser_a
			always_ff @(posedge clk) begin
				if (en)
					smh_a[i] <= 61'(side_in.x2) * 61'(sh);
			end
		end

		assign cp_r = rnd30({1'b0, cmh_a[i]});
		assign cv   = ({1'b0, cp_r} + 32'(COS_HK[i])) >> COS_J[i];
		assign cw   = cv[29:0];

		always_ff @(posedge clk) begin
			if (en) begin
				cpd_b[i]  <= 61'(cw) * 61'(COS_M[i]);
				side_b[i] <= side_a[i];
			end
		end

		if (i == 4) begin : g_sfin_b
			always_ff @(posedge clk) begin
				if (en)
					s_b4 <= rnd30({1'b0, smh_a[i]});
			end
		end else begin : g_sser_b
			logic [30:0] sp_r;
			logic [31:0] sv;
			logic [29:0] sw;

			assign sp_r = rnd30({1'b0, smh_a[i]});
			assign sv   = ({1'b0, sp_r} + 32'(SIN_HK[i])) >> SIN_J[i];
			assign sw   = sv[29:0];

			always_ff @(posedge clk) begin
				if (en)
					spd_b[i] <= 61'(sw) * 61'(SIN_M[i]);
			end
		end
	end

	assign c_fin = ONE_Q30 - 31'(cpd_b[4] >> COS_S[4]);
	assign ss    = side_b[4].swap ? c_fin : s_b4;
	assign cc    = side_b[4].swap ? s_b4 : c_fin;
	assign ss_v  = $signed({1'b0, ss});
	assign cc_v  = $signed({1'b0, cc});

	always_ff @(posedge clk) begin
		if (en) begin
			case (side_b[4].quad)
				2'd0: begin
					sin_s19 <= ss_v;
					cos_s19 <= cc_v;
				end
				2'd1: begin
					sin_s19 <= cc_v;
					cos_s19 <= -ss_v;
				end
				2'd2: begin
					sin_s19 <= -ss_v;
					cos_s19 <= -cc_v;
				end
				default: begin
					sin_s19 <= -cc_v;
					cos_s19 <= ss_v;
				end
			endcase
		end
	end

	assign sin_q30 = sin_s19;
	assign cos_q30 = cos_s19;

endmodule
